FILE: design/ide_pio_disk_controller_macros.svh
// assertion macros for the ide controller checker
`ifndef IDE_PIO_DISK_CONTROLLER_MACROS_SVH
`define IDE_PIO_DISK_CONTROLLER_MACROS_SVH

// implication checked on every clock edge outside reset
`define IDE_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ide check failed");

// next-cycle implication checked outside reset
`define IDE_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ide check failed");

`endif

FILE: design/ide_pkg.sv
package ide_pkg;

   localparam int DriveSectors = 64;
   localparam int SectorBytes = 512;
   localparam int MaxAccessBytes = 4;
   localparam int SecW = 7;
   localparam int OffW = 10;
   localparam int StoreBytes = 4 * DriveSectors * SectorBytes;
   localparam int AddrW = $clog2(StoreBytes);

   localparam logic [15:0] Ch0Base = 16'h01f0;
   localparam logic [15:0] Ch1Base = 16'h0170;
   localparam logic [7:0] CmdRead = 8'h20;
   localparam logic [7:0] CmdWrite = 8'h30;
   localparam logic [7:0] CmdIdent = 8'hEC;
   localparam logic [7:0] StatusReady = 8'h40;
   localparam logic [9:0] LbaAt = 10'd120;
   localparam logic [9:0] LbaExtAt = 10'd200;
   localparam logic [9:0] ModelAt = 10'd54;
   localparam logic [9:0] ModelLen = 10'd40;

   localparam logic [2:0] RegData = 3'd0;
   localparam logic [2:0] RegCount = 3'd2;
   localparam logic [2:0] RegSector = 3'd3;
   localparam logic [2:0] RegCylLo = 3'd4;
   localparam logic [2:0] RegCylHi = 3'd5;
   localparam logic [2:0] RegHead = 3'd6;
   localparam logic [2:0] RegCmd = 3'd7;

   localparam logic [2:0] CsrMask = 3'd0;
   localparam logic [2:0] CsrSecs0 = 3'd1;
   localparam logic [2:0] CsrSecs1 = 3'd2;
   localparam logic [2:0] CsrSecs2 = 3'd3;
   localparam logic [2:0] CsrSecs3 = 3'd4;

   typedef struct packed {
      logic kind;
      logic [15:0] port;
      logic [2:0] access_bytes;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic error;
   } rsp_type;

   typedef struct packed {
      logic wr;
      logic [AddrW-1:0] addr;
      logic [7:0] wdata;
   } mem_cmd_type;

   function automatic logic [31:0] ident_word(input logic [6:0] w);
      logic [31:0] r;
      begin
         case (w)
            7'd0: r = 32'h90040; 7'd1: r = 32'h100000; 7'd2: r = 32'h2007e00;
            7'd3: r = 32'h3f; 7'd5: r = 32'h3030514d; 7'd6: r = 32'h31203030;
            7'd7: r = 32'h20202020; 7'd8: r = 32'h20202020; 7'd9: r = 32'h20202020;
            7'd10: r = 32'h2000003; 7'd11: r = 32'h322e0004; 7'd12: r = 32'h2020352b;
            7'd13: r = 32'h51452020; 7'd14: r = 32'h20484d55; 7'd15: r = 32'h44444152;
            7'd16: r = 32'h4b204953; 7'd17: r = 32'h20202020; 7'd18: r = 32'h20202020;
            7'd19: r = 32'h20202020; 7'd20: r = 32'h20202020; 7'd21: r = 32'h20202020;
            7'd22: r = 32'h20202020; 7'd23: r = 32'h80102020; 7'd24: r = 32'hb000001;
            7'd25: r = 32'h2000000; 7'd26: r = 32'h70200; 7'd27: r = 32'h100009;
            7'd28: r = 32'h2370003f; 7'd29: r = 32'h1100000; 7'd30: r = 32'h2710;
            7'd31: r = 32'h70007; 7'd32: r = 32'h780003; 7'd33: r = 32'h780078;
            7'd34: r = 32'h40000078; 7'd40: r = 32'h1600f0; 7'd41: r = 32'h74004021;
            7'd42: r = 32'h40214000; 7'd43: r = 32'h40003400; 7'd44: r = 32'h203f;
            7'd46: r = 32'h60010000; 7'd50: r = 32'h2710; 7'd53: r = 32'h6000;
            7'd84: r = 32'h10000;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

   function automatic logic [7:0] model_byte(input logic [5:0] k);
      logic [7:0] r;
      begin
         case (k)
            6'd0: r = 8'h43; 6'd1: r = 8'h52; 6'd2: r = 8'h52; 6'd3: r = 8'h4F;
            6'd4: r = 8'h20; 6'd5: r = 8'h45; 6'd6: r = 8'h4D; 6'd7: r = 8'h56;
            6'd8: r = 8'h20; 6'd9: r = 8'h4D; 6'd10: r = 8'h41; 6'd11: r = 8'h48;
            6'd12: r = 8'h44; 6'd13: r = 8'h52; 6'd14: r = 8'h49; 6'd15: r = 8'h44;
            6'd16: r = 8'h4B; 6'd17: r = 8'h53;
            default: r = 8'h20;
         endcase
         return r;
      end
   endfunction

   function automatic logic [7:0] ident_byte(input logic [9:0] off, input logic [SecW-1:0] secs);
      logic [9:0] k;
      logic [31:0] w;
      logic [31:0] s;
      begin
         s = 32'(secs);
         w = ident_word(off[8:2]);
         k = off - ModelAt;
         if (off >= LbaAt && off < LbaAt + 10'd4) begin
            w = s;
         end else if (off >= LbaExtAt && off < LbaExtAt + 10'd4) begin
            w = s;
         end else if (off >= ModelAt && off < ModelAt + ModelLen) begin
            w = {4{model_byte(k[5:0])}};
         end
         return w[8*off[1:0] +: 8];
      end
   endfunction

endpackage

FILE: design/ide_store.sv
module ide_store
   import ide_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_cmd_type cmd,
   input  logic        cmd_valid,
   output logic [7:0]  rdata,
   output logic        clear_done
);
   logic [7:0] mem [StoreBytes];
   logic [AddrW:0] clr_ff, clr_in;

   assign clear_done = clr_ff[AddrW];
   assign clr_in = clear_done ? clr_ff : clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!clear_done) begin
         mem[clr_ff[AddrW-1:0]] <= 8'h00;
      end else if (cmd_valid && cmd.wr) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      rdata <= mem[cmd.addr];
   end
endmodule

FILE: design/ide_pio_disk_controller.sv
// One bus access per start pulse; busy stays high until its rsp_valid beat, which lasts one
// cycle and cannot be stalled, and the next start is taken in the cycle after that beat.
// Register accesses and refused data accesses pass through S_DEC and S_DONE only; store
// transfers add an S_BYTE access step and an S_WAIT wait step for every byte, since
// every byte goes through the single byte-wide store port; identify reads add an S_BYTE
// step for every byte. After reset the store is zeroed one byte per cycle while busy is high;
// csr writes are taken throughout.
module ide_pio_disk_controller
   import ide_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_DEC = 5'b00010, S_BYTE = 5'b00100,
      S_WAIT = 5'b01000, S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [3:0] mask_ff, mask_in;
   logic [SecW-1:0] secs_ff [4], secs_in [4];
   logic [27:0] sec_ff [2], sec_in [2];
   logic dsel_ff [2], dsel_in [2];
   logic [7:0] cmdc_ff [2], cmdc_in [2];
   logic [OffW-1:0] off_ff [2], off_in [2];
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] nb_ff, nb_in;
   logic [1:0] mode_ff, mode_in;
   logic [31:0] rd_ff, rd_in;
   logic err_ff, err_in;
   logic ch;
   logic [2:0] reg_sel;
   logic hit;
   logic [1:0] drv;
   logic [SecW-1:0] cap;
   logic csr_wr;
   logic [2:0] csr_idx;
   mem_cmd_type mcmd;
   logic mvalid;
   logic mvalid_q;
   logic [7:0] mrd;
   logic clear_done;
   logic [7:0] wbyte;

   localparam logic [1:0] ModeIdent = 2'd1;
   localparam logic [1:0] ModeXfer = 2'd2;

   ide_store u_store (
      .clock, .reset, .cmd(mcmd), .cmd_valid(mvalid), .rdata(mrd), .clear_done
   );

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];
   assign busy = (state_ff != S_IDLE) || !clear_done;

   always_comb begin
      case (csr_idx)
         CsrMask:  prdata = 32'(mask_ff);
         CsrSecs0: prdata = 32'(secs_ff[0]);
         CsrSecs1: prdata = 32'(secs_ff[1]);
         CsrSecs2: prdata = 32'(secs_ff[2]);
         CsrSecs3: prdata = 32'(secs_ff[3]);
         default:  prdata = 32'h0;
      endcase
   end

   assign hit = (req_ff.port[15:3] == Ch0Base[15:3]) || (req_ff.port[15:3] == Ch1Base[15:3]);
   assign ch = (req_ff.port[15:3] == Ch1Base[15:3]);
   assign reg_sel = req_ff.port[2:0];
   assign drv = {ch, dsel_ff[ch]};
   assign cap = (secs_ff[drv] > SecW'(DriveSectors)) ? SecW'(DriveSectors) : secs_ff[drv];
   assign wbyte = req_ff.write_data[8*cnt_ff[1:0] +: 8];

   always_comb begin
      mcmd.wr = req_ff.kind;
      mcmd.addr = AddrW'({drv, sec_ff[ch][5:0], off_ff[ch][8:0]});
      mcmd.wdata = wbyte;
      mvalid = (state_ff == S_BYTE) && (mode_ff == ModeXfer)
               && (sec_ff[ch] < 28'(cap));
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      mask_in = mask_ff;
      secs_in = secs_ff;
      sec_in = sec_ff;
      dsel_in = dsel_ff;
      cmdc_in = cmdc_ff;
      off_in = off_ff;
      cnt_in = cnt_ff;
      nb_in = nb_ff;
      mode_in = mode_ff;
      rd_in = rd_ff;
      err_in = err_ff;
      if (csr_wr) begin
         case (csr_idx)
            CsrMask:  mask_in = pwdata[3:0];
            CsrSecs0: secs_in[0] = pwdata[SecW-1:0];
            CsrSecs1: secs_in[1] = pwdata[SecW-1:0];
            CsrSecs2: secs_in[2] = pwdata[SecW-1:0];
            CsrSecs3: secs_in[3] = pwdata[SecW-1:0];
            default: ;
         endcase
      end
      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               req_in = req_data;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            rd_in = '0;
            err_in = 1'b0;
            cnt_in = '0;
            mode_in = '0;
            nb_in = (req_ff.access_bytes > 3'(MaxAccessBytes))
                    ? 3'(MaxAccessBytes) : req_ff.access_bytes;
            state_in = S_DONE;
            if (!hit) begin
               err_in = 1'b1;
            end else if (reg_sel == RegData) begin
               if (!req_ff.kind && cmdc_ff[ch] == CmdIdent) begin
                  mode_in = ModeIdent;
                  state_in = S_BYTE;
               end else if ((!req_ff.kind && cmdc_ff[ch] == CmdRead)
                            || (req_ff.kind && cmdc_ff[ch] == CmdWrite)) begin
                  mode_in = ModeXfer;
                  state_in = S_BYTE;
               end else begin
                  err_in = 1'b1;
               end
            end else if (!req_ff.kind) begin
               if (reg_sel == RegCmd) begin
                  rd_in = mask_ff[drv] ? 32'(StatusReady) : 32'h0;
               end else begin
                  err_in = 1'b1;
               end
            end else begin
               case (reg_sel)
                  RegCount: ;
                  RegSector: sec_in[ch][7:0] = req_ff.write_data[7:0];
                  RegCylLo:  sec_in[ch][15:8] = req_ff.write_data[7:0];
                  RegCylHi:  sec_in[ch][23:16] = req_ff.write_data[7:0];
                  RegHead: begin
                     sec_in[ch][27:24] = req_ff.write_data[3:0];
                     dsel_in[ch] = req_ff.write_data[4];
                  end
                  RegCmd: begin
                     cmdc_in[ch] = req_ff.write_data[7:0];
                     off_in[ch] = '0;
                  end
                  default: err_in = 1'b1;
               endcase
            end
            if (state_in == S_BYTE && req_ff.access_bytes == 3'd0) begin
               state_in = S_DONE;
            end
         end
         S_BYTE: begin
            if (mode_ff == ModeIdent) begin
               if (off_ff[ch] < OffW'(SectorBytes)) begin
                  rd_in[8*cnt_ff[1:0] +: 8] = ident_byte(off_ff[ch], cap);
                  off_in[ch] = off_ff[ch] + 1'b1;
               end else begin
                  err_in = 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
               state_in = (cnt_in == nb_ff) ? S_DONE : S_BYTE;
            end else begin
               if (!(sec_ff[ch] < 28'(cap))) begin
                  err_in = 1'b1;
               end
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (mvalid_q) begin
               rd_in[8*cnt_ff[1:0] +: 8] = mrd;
            end
            if (off_ff[ch][8:0] == 9'h1ff) begin
               off_in[ch] = '0;
               sec_in[ch] = sec_ff[ch] + 1'b1;
            end else begin
               off_in[ch] = OffW'(off_ff[ch][8:0]) + 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_in == nb_ff) ? S_DONE : S_BYTE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mvalid_q <= mvalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mask_ff <= '0;
         secs_ff <= '{default: '0};
         sec_ff <= '{default: '0};
         dsel_ff <= '{default: 1'b0};
         cmdc_ff <= '{default: '0};
         off_ff <= '{default: '0};
      end else begin
         state_ff <= state_in;
         mask_ff <= mask_in;
         secs_ff <= secs_in;
         sec_ff <= sec_in;
         dsel_ff <= dsel_in;
         cmdc_ff <= cmdc_in;
         off_ff <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      cnt_ff <= cnt_in;
      nb_ff <= nb_in;
      mode_ff <= mode_in;
      rd_ff <= rd_in;
      err_ff <= err_in;
   end

   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data.read_data = (req_ff.kind || err_ff) ? 32'h0 : rd_ff;
   assign rsp_data.error = err_ff;
endmodule

FILE: design/ide_checker.sv
`include "ide_pio_disk_controller_macros.svh"
module ide_checker
   import ide_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   `IDE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `IDE_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy)
   `IDE_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_data.error, rsp_data.read_data == 32'h0)
   `IDE_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
endmodule

bind ide_pio_disk_controller ide_checker u_ide_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_data
);
